>>> hdl/gpd_pkg.sv
// gpd_pkg: constants, latency figures and the arctangent table shared by
// the track-point distance pipeline. No dependencies.
package gpd_pkg;

  // number of cordic micro-rotations, each one pipeline stage
  localparam int CordicSteps = 32;

  // angle reduction constants in half-units (5e-8 degree)
  localparam logic signed [34:0] HalfFullTurn    = 35'sd7200000000;
  localparam logic signed [34:0] HalfHalfTurn    = 35'sd3600000000;
  localparam logic signed [34:0] HalfQuarterTurn = 35'sd1800000000;

  localparam logic [28:0] DegToRadQ28 = 29'd503056907;
  localparam logic signed [33:0] CordicGainInv = 34'sd652032874;
  localparam logic [32:0] EarthRMm = 33'd6378137000;
  localparam logic [27:0] MmPerUnitQ24 = 28'd186763114;
  localparam logic signed [32:0] FlatLimit = 33'sd2000000;
  localparam logic [35:0] DistMax = 36'd20040000000;
  localparam logic [30:0] OneQ30 = 31'd1073741824;

  // square root pipeline: 62-bit radicand, one root bit per stage
  localparam int IsqRadW  = 62;
  localparam int IsqRootW = 31;

  // stage counts of the pipeline sections
  localparam int ScLat     = CordicSteps + 4;
  localparam int HavLat    = CordicSteps + 36;
  localparam int FlatLat   = 2 * IsqRootW + 6;
  localparam int FlatDeTap = IsqRootW + 4;
  localparam int BrLat     = (HavLat > FlatLat) ? HavLat : FlatLat;
  localparam int HavPad    = BrLat - HavLat;
  localparam int FlatPad   = BrLat - FlatLat;

  // configuration register indexes
  localparam logic [1:0] CfgForceHav = 2'd0;
  localparam logic [1:0] CfgUseEle   = 2'd1;

  // atan(2^-i) in Q30
  function automatic logic signed [32:0] atan_q30(input int i);
    logic signed [32:0] v;
    case (i)
      0:  v = 33'sh03243F6A8;
      1:  v = 33'sh01DAC6705;
      2:  v = 33'sh00FADBAFC;
      3:  v = 33'sh007F56EA6;
      4:  v = 33'sh003FEAB76;
      5:  v = 33'sh001FFD55B;
      6:  v = 33'sh000FFFAAA;
      7:  v = 33'sh0007FFF55;
      8:  v = 33'sh0003FFFEA;
      9:  v = 33'sh0001FFFFD;
      10: v = 33'sh0000FFFFF;
      11: v = 33'sh00007FFFF;
      12: v = 33'sh00003FFFF;
      13: v = 33'sh00001FFFF;
      14: v = 33'sh00000FFFF;
      15: v = 33'sh000007FFF;
      16: v = 33'sh000003FFF;
      17: v = 33'sh000001FFF;
      18: v = 33'sh000000FFF;
      19: v = 33'sh0000007FF;
      20: v = 33'sh0000003FF;
      21: v = 33'sh0000001FF;
      22: v = 33'sh0000000FF;
      23: v = 33'sh00000007F;
      24: v = 33'sh00000003F;
      25: v = 33'sh00000001F;
      26: v = 33'sh00000000F;
      27: v = 33'sh000000008;
      28: v = 33'sh000000004;
      29: v = 33'sh000000002;
      30: v = 33'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/gps_point_distance_unit.sv
// gps_point_distance_unit: top level, input and configuration ports,
// front end, branch alignment and saturating output register.
// Depends on gpd_pkg, gpd_sincos, gpd_hav, gpd_flat.

// Distance between two track points in millimetres. One pair is accepted
// every clock cycle unless the output stalls; the pipeline depth is set by
// the chain of cordic rotation stages and the one-bit-per-stage square root
// pipelines. The whole pipeline freezes while the output register holds a
// result that is not taken, so nothing is lost or repeated.
// The haversine path is selected when force_haversine is set or either
// coordinate difference exceeds 0.2 degree; configuration writes are taken
// at any time and should be made while the pipeline is empty.
module gps_point_distance_unit import gpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] lat_a_i,
  input  logic signed [31:0] lon_a_i,
  input  logic signed [24:0] ele_a_i,
  input  logic signed [30:0] lat_b_i,
  input  logic signed [31:0] lon_b_i,
  input  logic signed [24:0] ele_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [34:0]        dist_mm_o,
  output logic               took_haversine_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic               cfg_data_i
);

  localparam int NumStages = ScLat + BrLat + 2;

  typedef struct packed {
    logic               valid;
    logic               hav;
    logic signed [21:0] dlat;
    logic signed [21:0] dlon;
    logic signed [25:0] de;
  } ctl_t;

  logic force_hav_q, use_ele_q;
  ctl_t ctl_q [NumStages];
  ctl_t ctl_d;
  logic en;
  logic signed [33:0] ang_la_q, ang_lb_q, ang_dlat_q, ang_dlon_q;
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic signed [31:0] c1, c2, s1, s2;
  logic [35:0] hav_dist, flat_dist, hav_al, flat_al;
  logic [35:0] sel_dist;
  logic [34:0] dist_q;
  ctl_t ctl_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_hav_q <= 1'b0;
      use_ele_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgForceHav: force_hav_q <= cfg_data_i;
        CfgUseEle:   use_ele_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result waits at the output
  assign en          = !ctl_out.valid || out_ready_i;
  assign in_ready_o  = en;

  // front end: differences and branch decision
  assign dlat = 32'(lat_b_i) - 32'(lat_a_i);
  assign dlon = 33'(lon_b_i) - 33'(lon_a_i);

  always_comb begin
    ctl_d.valid = in_valid_i;
    ctl_d.hav   = force_hav_q || (33'(dlat) > FlatLimit) || (33'(dlat) < -FlatLimit)
                  || (dlon > FlatLimit) || (dlon < -FlatLimit);
    ctl_d.dlat  = dlat[21:0];
    ctl_d.dlon  = dlon[21:0];
    ctl_d.de    = 26'(ele_b_i) - 26'(ele_a_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_la_q   <= 34'(lat_a_i) <<< 1;
      ang_lb_q   <= 34'(lat_b_i) <<< 1;
      ang_dlat_q <= 34'(dlat);
      ang_dlon_q <= 34'(dlon);
    end
  end

  // control chain: valid, branch flag and side operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStages; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl_d;
      for (int k = 1; k < NumStages; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  assign ctl_out = ctl_q[NumStages-1];

  // trigonometry
  gpd_sincos u_sc_lat_b (
    .clk_i (clk_i), .en_i (en),
    .ang_i (ang_lb_q), .sin_o (), .cos_o (c1)
  );

  gpd_sincos u_sc_lat_a (
    .clk_i (clk_i), .en_i (en),
    .ang_i (ang_la_q), .sin_o (), .cos_o (c2)
  );

  gpd_sincos u_sc_dlat (
    .clk_i (clk_i), .en_i (en),
    .ang_i (ang_dlat_q), .sin_o (s1), .cos_o ()
  );

  gpd_sincos u_sc_dlon (
    .clk_i (clk_i), .en_i (en),
    .ang_i (ang_dlon_q), .sin_o (s2), .cos_o ()
  );

  // branches
  gpd_hav u_hav (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .s1_i   (s1),
    .s2_i   (s2),
    .c1_i   (c1),
    .c2_i   (c2),
    .dist_o (hav_dist)
  );

  gpd_flat u_flat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .use_ele_i (use_ele_q),
    .c1_i      (c1),
    .dlat_i    (ctl_q[ScLat].dlat),
    .dlon_i    (ctl_q[ScLat].dlon),
    .de_i      (ctl_q[ScLat+FlatDeTap].de),
    .dist_o    (flat_dist)
  );

  // align the two branches
  if (HavPad > 0) begin : g_hav_pad
    logic [35:0] pad_q [HavPad];
    always_ff @(posedge clk_i) begin
      if (en) begin
        pad_q[0] <= hav_dist;
        for (int k = 1; k < HavPad; k++) begin
          pad_q[k] <= pad_q[k-1];
        end
      end
    end
    assign hav_al = pad_q[HavPad-1];
  end else begin : g_hav_nopad
    assign hav_al = hav_dist;
  end

  if (FlatPad > 0) begin : g_flat_pad
    logic [35:0] pad_q [FlatPad];
    always_ff @(posedge clk_i) begin
      if (en) begin
        pad_q[0] <= flat_dist;
        for (int k = 1; k < FlatPad; k++) begin
          pad_q[k] <= pad_q[k-1];
        end
      end
    end
    assign flat_al = pad_q[FlatPad-1];
  end else begin : g_flat_nopad
    assign flat_al = flat_dist;
  end

  // branch select and saturation into the output register
  assign sel_dist = ctl_q[NumStages-2].hav ? hav_al : flat_al;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (sel_dist > DistMax) ? DistMax[34:0] : sel_dist[34:0];
    end
  end

  assign out_valid_o      = ctl_out.valid;
  assign took_haversine_o = ctl_out.hav;
  assign dist_mm_o        = dist_q;

endmodule

>>> hdl/gpd_isqrt.sv
// gpd_isqrt: pipelined integer floor square root, one root bit per stage.
// Depends on gpd_pkg.
module gpd_isqrt import gpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [IsqRadW-1:0]  rad_i,
  output logic [IsqRootW-1:0] root_o
);

  logic [IsqRootW+1:0]  rem_q  [IsqRootW];
  logic [IsqRootW-1:0]  root_q [IsqRootW];
  logic [IsqRadW-1:0]   rest_q [IsqRootW];

  for (genvar k = 0; k < IsqRootW; k++) begin : g_step
    logic [IsqRootW+1:0] rem_p;
    logic [IsqRootW-1:0] root_p;
    logic [IsqRadW-1:0]  rest_p;
    logic [IsqRootW+3:0] rem_in;
    logic [IsqRootW+3:0] trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rest_p = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rest_p = rest_q[k-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_in = {rem_p, rest_p[IsqRadW-1 -: 2]};
    assign trial  = {2'b00, root_p, 2'b01};
    assign ge     = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q[k] <= '0;
      end else if (en_i) begin
        rem_q[k] <= ge ? (rem_in[IsqRootW+1:0] - trial[IsqRootW+1:0])
                       : rem_in[IsqRootW+1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_p[IsqRootW-2:0], ge};
        rest_q[k] <= {rest_p[IsqRadW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[IsqRootW-1];

endmodule

>>> hdl/gpd_sincos.sv
// gpd_sincos: angle reduction, degree to radian scaling and a rotation
// cordic, one micro-rotation per stage. Depends on gpd_pkg.
module gpd_sincos import gpd_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] ang_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic signed [34:0] red_q;
  logic [30:0]        mag_q;
  logic               neg_q;
  logic               fold_flip_q;
  logic signed [33:0] x_q [CordicSteps+1];
  logic signed [33:0] y_q [CordicSteps+1];
  logic signed [32:0] z_q [CordicSteps+1];
  logic               flip_q [CordicSteps+1];

  logic signed [34:0] ang_ext;
  logic signed [34:0] fold_d;
  logic               flip_d;
  logic signed [34:0] fold_abs;
  logic [59:0]        prod;
  logic [30:0]        zm;

  // reduce into [-180, 180) degree
  assign ang_ext = 35'(ang_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ang_ext >= HalfHalfTurn) begin
        red_q <= ang_ext - HalfFullTurn;
      end else if (ang_ext < -HalfHalfTurn) begin
        red_q <= ang_ext + HalfFullTurn;
      end else begin
        red_q <= ang_ext;
      end
    end
  end

  // fold into [-90, 90] degree, folding flips the cosine
  always_comb begin
    fold_d = red_q;
    flip_d = 1'b0;
    if (red_q > HalfQuarterTurn) begin
      fold_d = HalfHalfTurn - red_q;
      flip_d = 1'b1;
    end else if (red_q < -HalfQuarterTurn) begin
      fold_d = -HalfHalfTurn - red_q;
      flip_d = 1'b1;
    end
  end

  assign fold_abs = fold_d[34] ? -fold_d : fold_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q       <= fold_abs[30:0];
      neg_q       <= fold_d[34];
      fold_flip_q <= flip_d;
    end
  end

  // scale to radians in Q30 with rounding
  assign prod = 60'(mag_q) * 60'(DegToRadQ28) + 60'(1 << 28);
  assign zm   = prod[59:29];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CordicGainInv;
      y_q[0]    <= '0;
      z_q[0]    <= neg_q ? -$signed({2'b00, zm}) : $signed({2'b00, zm});
      flip_q[0] <= fold_flip_q;
    end
  end

  // rotation micro-steps
  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  // output register with the cosine sign fix
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= y_q[CordicSteps][31:0];
      cos_o <= flip_q[CordicSteps] ? 32'(-x_q[CordicSteps]) : x_q[CordicSteps][31:0];
    end
  end

endmodule

>>> hdl/gpd_vector.sv
// gpd_vector: vectoring cordic that accumulates atan2(y, x) in Q30,
// one micro-rotation per stage. Depends on gpd_pkg.
module gpd_vector import gpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [IsqRootW-1:0] x_i,
  input  logic [IsqRootW-1:0] y_i,
  output logic signed [32:0]  z_o
);

  logic signed [33:0] x_q [CordicSteps];
  logic signed [33:0] y_q [CordicSteps];
  logic signed [32:0] z_q [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_vec
    logic signed [33:0] xp;
    logic signed [33:0] yp;
    logic signed [32:0] zp;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    if (i == 0) begin : g_first
      assign xp = $signed(34'(x_i));
      assign yp = $signed(34'(y_i));
      assign zp = '0;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
    end

    assign dx = yp >>> i;
    assign dy = xp >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        z_q[i] <= '0;
      end else if (en_i) begin
        z_q[i] <= (yp >= 0) ? zp + atan_q30(i) : zp - atan_q30(i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yp >= 0) begin
          x_q[i] <= xp + dx;
          y_q[i] <= yp - dy;
        end else begin
          x_q[i] <= xp - dx;
          y_q[i] <= yp + dy;
        end
      end
    end
  end

  assign z_o = z_q[CordicSteps-1];

endmodule

>>> hdl/gpd_hav.sv
// gpd_hav: haversine branch, products and clamp, two square roots, central
// angle by vectoring and scaling by the earth radius.
// Depends on gpd_pkg, gpd_isqrt, gpd_vector.
module gpd_hav import gpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic signed [31:0] s1_i,
  input  logic signed [31:0] s2_i,
  input  logic signed [31:0] c1_i,
  input  logic signed [31:0] c2_i,
  output logic [35:0]        dist_o
);

  logic signed [33:0] p1_q, p2_q, pc_q, p1b_q, q_q;
  logic [30:0]        a_q;
  logic signed [63:0] s1sq, s2sq, ccp;
  logic signed [67:0] qp;
  logic signed [34:0] asum;
  logic [30:0]        b;
  logic [IsqRootW-1:0] root_a, root_b;
  logic signed [32:0] z;
  logic [30:0]        zc;
  logic [47:0]        lo_q;
  logic [46:0]        hi_q;
  logic [64:0]        dsum;

  // squares of the half-angle sines and product of the cosines
  assign s1sq = s1_i * s1_i;
  assign s2sq = s2_i * s2_i;
  assign ccp  = c1_i * c2_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= s1sq[63:30];
      p2_q <= s2sq[63:30];
      pc_q <= ccp[63:30];
    end
  end

  assign qp = p2_q * pc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= qp[63:30];
      p1b_q <= p1_q;
    end
  end

  // haversine term clamped to [0, 1]
  assign asum = 35'(p1b_q) + 35'(q_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (asum < 0) begin
        a_q <= '0;
      end else if (asum > $signed(35'(OneQ30))) begin
        a_q <= OneQ30;
      end else begin
        a_q <= asum[30:0];
      end
    end
  end

  assign b = OneQ30 - a_q;

  gpd_isqrt u_sqrt_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .rad_i  ({1'b0, a_q, 30'd0}),
    .root_o (root_a)
  );

  gpd_isqrt u_sqrt_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .rad_i  ({1'b0, b, 30'd0}),
    .root_o (root_b)
  );

  gpd_vector u_vector (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .x_i    (root_b),
    .y_i    (root_a),
    .z_o    (z)
  );

  // negative angle counts as zero; radius product split in two halves
  assign zc = z[32] ? 31'd0 : z[30:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= 48'(zc) * 48'(EarthRMm[16:0]);
      hi_q <= 47'(zc) * 47'(EarthRMm[32:17]);
    end
  end

  assign dsum = {1'b0, hi_q, 17'd0} + 65'(lo_q) + 65'(1 << 28);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_o <= dsum[64:29];
    end
  end

endmodule

>>> hdl/gpd_flat.sv
// gpd_flat: flat-earth branch, scaled coordinate squares, square root,
// unit conversion and the optional elevation term in quadrature.
// Depends on gpd_pkg, gpd_isqrt.
module gpd_flat import gpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               use_ele_i,
  input  logic signed [31:0] c1_i,
  input  logic signed [21:0] dlat_i,
  input  logic signed [21:0] dlon_i,
  input  logic signed [25:0] de_i,
  output logic [35:0]        dist_o
);

  logic [59:0]        xx_q, xxb_q;
  logic signed [53:0] yp_q;
  logic [61:0]        yy_q;
  logic [61:0]        s_q;
  logic [26:0]        d_q;
  logic [53:0]        dd_q;
  logic [50:0]        ee_q;
  logic [54:0]        e_sum_q;
  logic signed [43:0] dsq;
  logic signed [31:0] y8;
  logic signed [63:0] ysq;
  logic signed [51:0] desq;
  logic [IsqRootW-1:0] r8, rout;
  logic [59:0]        dprod;

  // latitude term and longitude scaled by the cosine
  assign dsq = dlat_i * dlat_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= {dsq[43:0], 16'd0};
      yp_q <= dlon_i * c1_i;
    end
  end

  assign y8  = yp_q[53:22];
  assign ysq = y8 * y8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yy_q  <= ysq[61:0];
      xxb_q <= xx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= 62'(xxb_q) + yy_q;
    end
  end

  gpd_isqrt u_sqrt_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .rad_i  (s_q),
    .root_o (r8)
  );

  // convert to millimetres with rounding
  assign dprod = 60'(r8) * 60'(MmPerUnitQ24) + 60'(64'd1 << 31);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= dprod[58:32];
    end
  end

  // squares for the quadrature sum; without elevation the root gives d back
  assign desq = de_i * de_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q <= 54'(d_q) * 54'(d_q);
      ee_q <= use_ele_i ? desq[50:0] : 51'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_sum_q <= 55'(dd_q) + 55'(ee_q);
    end
  end

  gpd_isqrt u_sqrt_e (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .rad_i  (62'(e_sum_q)),
    .root_o (rout)
  );

  assign dist_o = 36'(rout);

endmodule

>>> tb/tb_gps_point_distance_unit.sv
// tb_gps_point_distance_unit: self-checking bench for the track-point distance
// pipeline, with a fixed-point distance predictor and an in-order result board.
// Depends on gpd_pkg and the gps_point_distance_unit rtl.
`timescale 1ns / 100ps

module tb_gps_point_distance_unit;
  import gpd_pkg::*;

  localparam int WatchLimit = 3000;
  localparam int DrainCycles = 120;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 500;
  localparam logic [1:0] CfgSpare = 2'd2;

  typedef struct {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [24:0] ele_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic signed [24:0] ele_b;
  } track_pair_t;

  typedef struct {
    logic [34:0] dist_mm;
    logic        hav;
  } distance_t;

  // fixed-point great-circle / flat distance predictor plus pending results
  class distance_board;
    distance_t pending[$];
    int errors;
    bit force_hav;
    bit use_ele;

    static function automatic longint atan_entry(int i);
      longint tbl[31] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001};
      if (i > 30) return 0;
      return tbl[i];
    endfunction

    static function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    // h in units of 5e-8 degree; sin and cos in q30
    static function automatic void rotate_half(longint h, output longint s,
                                               output longint c);
      longint r, z, x, y, dx, dy;
      longint unsigned mag;
      bit flip;
      r = h % 64'sd7200000000;
      flip = 0;
      if (r >= 64'sd3600000000) r -= 64'sd7200000000;
      if (r < -64'sd3600000000) r += 64'sd7200000000;
      if (r > 64'sd1800000000) begin
        r = 64'sd3600000000 - r;
        flip = 1;
      end
      if (r < -64'sd1800000000) begin
        r = -64'sd3600000000 - r;
        flip = 1;
      end
      mag = (r < 0) ? -r : r;
      z = longint'((mag * 64'd503056907 + (64'd1 << 28)) >> 29);
      if (r < 0) z = -z;
      x = 652032874;
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_entry(i);
        end else begin
          x += dx; y -= dy; z += atan_entry(i);
        end
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    static function automatic longint vector_z(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_entry(i);
        end else begin
          x -= dx; y += dy; z -= atan_entry(i);
        end
      end
      return z;
    endfunction

    function distance_t predict(track_pair_t p);
      distance_t d;
      longint dlat, dlon, s1, s2, c1, c2, unused, a, z, x8, y8, de;
      longint unsigned span;
      dlat = longint'(p.lat_b) - longint'(p.lat_a);
      dlon = longint'(p.lon_b) - longint'(p.lon_a);
      d.hav = force_hav || dlat > 2000000 || dlat < -2000000 ||
              dlon > 2000000 || dlon < -2000000;
      rotate_half(2 * longint'(p.lat_b), unused, c1);
      if (d.hav) begin
        rotate_half(2 * longint'(p.lat_a), unused, c2);
        rotate_half(dlat, s1, unused);
        rotate_half(dlon, s2, unused);
        a = ((s1 * s1) >>> 30) + ((((s2 * s2) >>> 30) * ((c1 * c2) >>> 30)) >>> 30);
        if (a < 0) a = 0;
        if (a > 64'sd1073741824) a = 64'sd1073741824;
        z = vector_z(longint'(floor_root(longint'(64'sd1073741824 - a) << 30)),
                     longint'(floor_root(longint'(a) << 30)));
        if (z < 0) z = 0;
        // 64-bit wrap of the product is part of the behavior
        span = (longint'(z) * 64'd6378137000 + (64'd1 << 28)) >> 29;
      end else begin
        x8 = dlat * 256;
        y8 = (dlon * c1) >>> 22;
        span = floor_root(longint'(x8 * x8) + longint'(y8 * y8));
        span = (span * 64'd186763114 + (64'd1 << 31)) >> 32;
        if (use_ele) begin
          de = longint'(p.ele_b) - longint'(p.ele_a);
          span = floor_root(span * span + longint'(de * de));
        end
      end
      if (span > 64'd20040000000) span = 64'd20040000000;
      d.dist_mm = span[34:0];
      return d;
    endfunction

    function void set_reg(logic [1:0] idx, logic val);
      if (idx == CfgForceHav) force_hav = val;
      else if (idx == CfgUseEle) use_ele = val;
    endfunction

    function void note_pair(track_pair_t p);
      pending.push_back(predict(p));
    endfunction

    function void check_result(logic [34:0] got_dist, logic hav);
      distance_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result dist=%0d hav=%0b", $time, got_dist, hav);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got_dist !== e.dist_mm) begin
        $display("%0t: dist_mm expected %0d actual %0d", $time, e.dist_mm, got_dist);
        errors++;
      end
      if (hav !== e.hav) begin
        $display("%0t: took_haversine expected %0b actual %0b", $time, e.hav, hav);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic signed [30:0] lat_a_i, lat_b_i;
  logic signed [31:0] lon_a_i, lon_b_i;
  logic signed [24:0] ele_a_i, ele_b_i;
  logic out_valid_o, out_ready_i;
  logic [34:0] dist_mm_o;
  logic took_haversine_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic cfg_data_i;

  distance_board board;
  bit calm;
  bit hold_req;
  int quiet_cycles;

  gps_point_distance_unit dut (.*);

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // request and result monitor with inactivity watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        board.note_pair('{lat_a_i, lon_a_i, ele_a_i, lat_b_i, lon_b_i, ele_b_i});
      if (out_valid_o && out_ready_i) board.check_result(dist_mm_o, took_haversine_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("tb_gps_point_distance_unit: errors");
        $finish;
      end
    end
  end

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 7);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
    cfg_valid_i <= 0;
  endtask

  task automatic send_pair(track_pair_t p);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    lat_a_i <= p.lat_a; lon_a_i <= p.lon_a; ele_a_i <= p.ele_a;
    lat_b_i <= p.lat_b; lon_b_i <= p.lon_b; ele_b_i <= p.ele_b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic int near_delta();
    return $urandom_range(4000000) - 2000000;
  endfunction

  // mostly neighboring points, then boundary pairs, far pairs and raw noise
  function automatic track_pair_t random_pair();
    track_pair_t p;
    int kind;
    kind = $urandom_range(99);
    p.ele_a = 25'($urandom_range(11000000) - 1000000);
    p.ele_b = 25'($urandom_range(11000000) - 1000000);
    p.lat_a = 31'($urandom_range(1800000000) - 900000000);
    p.lon_a = $urandom_range(3600000000) - 1800000000;
    if (kind < 70) begin
      p.lat_b = 31'(p.lat_a + (kind < 20 ? $urandom_range(200) - 100 : near_delta()));
      p.lon_b = p.lon_a + (kind < 20 ? $urandom_range(200) - 100 : near_delta());
    end else if (kind < 80) begin
      p.lat_b = 31'(p.lat_a + ($urandom_range(1) ? 2000000 : -2000000)
                    + $urandom_range(1));
      p.lon_b = p.lon_a + near_delta();
    end else if (kind < 90) begin
      p.lat_b = 31'($urandom_range(1800000000) - 900000000);
      p.lon_b = $urandom_range(3600000000) - 1800000000;
    end else begin
      p = '{31'($urandom()), $urandom(), 25'($urandom()),
            31'($urandom()), $urandom(), 25'($urandom())};
    end
    return p;
  endfunction

  task automatic run_directed();
    track_pair_t dir[$];
    dir = '{
      '{0, 0, 0, 0, 0, 0},
      '{900000000, 0, 0, -900000000, 0, 0},
      '{0, 1799999000, 0, 0, -1799999000, 0},
      '{100, 200, 0, 2000100, 200, 0},
      '{100, 200, 0, 2000101, 200, 0},
      '{0, 2000000, 0, 0, 0, 0},
      '{0, -2000001, 0, 0, 0, 0},
      '{450000000, 0, -1000000, 450000010, 10, 10000000},
      '{-450000000, 5, 10000000, -450000000, 5, -1000000},
      '{0, 0, 0, 0, 1800000000, 0},
      '{0, -1800000000, 0, 0, 0, 0},
      '{31'h3fffffff, 32'h7fffffff, 25'hffffff, 31'h40000000, 32'h80000000, 25'h1000000},
      '{31'h3fffffff, 32'h7fffffff, 0, 31'h3ffffff0, 32'h7ffffff0, 0},
      '{900000000, 100, 0, 900000000, -100, 0},
      '{-900000000, 1000, 5, -899999000, -1000, 5},
      '{123456789, -987654321, 4321, 123456790, -987654300, -4321}
    };
    foreach (dir[i]) send_pair(dir[i]);
  endtask

  // stimulus: four register settings, each with directed and random pairs
  initial begin
    logic [1:0] cfg_set[4] = '{2'b00, 2'b10, 2'b01, 2'b11};
    board = new();
    rst_ni = 0;
    in_valid_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = '0;
    cfg_data_i = 0;
    lat_a_i = '0; lon_a_i = '0; ele_a_i = '0;
    lat_b_i = '0; lon_b_i = '0; ele_b_i = '0;
    calm = 0;
    hold_req = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // unused index must leave both registers alone
    write_reg(CfgSpare, 1);
    foreach (cfg_set[ph]) begin
      write_reg(CfgForceHav, cfg_set[ph][0]);
      write_reg(CfgUseEle, cfg_set[ph][1]);
      run_directed();
      for (int n = 0; n < PhaseItems; n++) begin
        calm = (ph == 2 && n < 200);
        if (ph == 1 && n == 100) hold_req = 1;
        if (ph == 3 && n == 250) drain_results();
        send_pair(random_pair());
      end
      calm = 0;
      drain_results();
    end
    if (board.errors == 0)
      $display("tb_gps_point_distance_unit: clean");
    else
      $display("tb_gps_point_distance_unit: errors");
    $finish;
  end

endmodule

>>> files.f
hdl/gpd_pkg.sv
hdl/gpd_isqrt.sv
hdl/gpd_sincos.sv
hdl/gpd_vector.sv
hdl/gpd_hav.sv
hdl/gpd_flat.sv
hdl/gps_point_distance_unit.sv
tb/tb_gps_point_distance_unit.sv
